[hw/rtl/shs_pkg.sv]
// Shared types and constants for the SHA-256 stream hasher.
package shs_pkg;

   localparam int WordBits = 32;
   localparam int Rounds   = 64;

   // SHA-256 initial hash value, element 0 is word a.
   localparam logic [7:0][WordBits-1:0] HASH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [WordBits-1:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   // Request mode codes
   localparam logic MODE_DATA   = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   // Sequencer to compression engine
   typedef struct packed {
      logic       push;       // shift one byte into the block buffer
      logic [7:0] push_byte;
      logic       start;      // run the 64 rounds over the buffer
      logic       init;       // reload the initial hash value
   } shs_ctl_type;

   // Compression engine to sequencer
   typedef struct packed {
      logic                       busy;
      logic [7:0][WordBits-1:0]   hash;
   } shs_sts_type;

endpackage

[hw/rtl/shs_ifs.sv]
// Handshake interfaces for the request and response channels.
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_word,
                   output ready);
endinterface

[hw/rtl/shs_compress.sv]
// Block buffer, message schedule and one-round-per-cycle compression engine.
module shs_compress
   import shs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  shs_ctl_type ctl,
   output shs_sts_type sts
);

   localparam logic [1:0] P_IDLE   = 2'd0;
   localparam logic [1:0] P_ROUND  = 2'd1;
   localparam logic [1:0] P_UPDATE = 2'd2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // The buffer doubles as the schedule window: word 0 (top bits) is W[t].
   logic [511:0]       sched_ff, sched_in;
   logic [7:0][31:0]   work_ff, work_in;
   logic [7:0][31:0]   hash_ff, hash_in;
   logic [1:0]         phase_ff, phase_in;
   logic [5:0]         round_ff, round_in;

   logic [31:0] w0, w1, w9, w14, w_next;
   logic [31:0] s0_big, s1_big, ch, maj, t1, t2;

   always_comb begin
      w0  = sched_ff[511 -: 32];
      w1  = sched_ff[479 -: 32];
      w9  = sched_ff[223 -: 32];
      w14 = sched_ff[63 -: 32];
      w_next = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
             + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

      s1_big = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1     = work_ff[7] + s1_big + ch + ROUND_K[round_ff] + w0;
      s0_big = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      maj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
             ^ (work_ff[1] & work_ff[2]);
      t2     = s0_big + maj;
   end

   always_comb begin
      sched_in = sched_ff;
      work_in  = work_ff;
      hash_in  = hash_ff;
      phase_in = phase_ff;
      round_in = round_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (ctl.push) begin
               sched_in = {sched_ff[503:0], ctl.push_byte};
            end
            if (ctl.init) begin
               hash_in = HASH_IV;
            end
            if (ctl.start) begin
               work_in  = hash_ff;
               round_in = '0;
               phase_in = P_ROUND;
            end
         end
         P_ROUND: begin
            sched_in   = {sched_ff[479:0], w_next};
            work_in[0] = t1 + t2;
            work_in[1] = work_ff[0];
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3] + t1;
            work_in[5] = work_ff[4];
            work_in[6] = work_ff[5];
            work_in[7] = work_ff[6];
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'(Rounds - 1)) begin
               phase_in = P_UPDATE;
            end
         end
         P_UPDATE: begin
            for (int k = 0; k < 8; k++) begin
               hash_in[k] = hash_ff[k] + work_ff[k];
            end
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         round_ff <= '0;
         hash_ff  <= HASH_IV;
      end else begin
         phase_ff <= phase_in;
         round_ff <= round_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      work_ff  <= work_in;
   end

   always_comb begin
      sts.busy = (phase_ff != P_IDLE);
      sts.hash = hash_ff;
   end

endmodule

[hw/rtl/sha256_stream_hasher_core.sv]
// SHA-256 stream hasher top level: byte intake, padding sequencer and digest output.
//
//   channel | direction | payload                               | accepted when
//   req     | in        | mode, data_byte                       | req.valid && req.ready
//   rsp     | out       | digest_word, word_index, last_word    | rsp.valid && rsp.ready
//
// The 64th byte of a block also starts the compression engine (64 rounds at
// one per cycle, one hash update, one hand-back). A finish pushes padding one byte
// a cycle while no compression runs (up to 8 + 56 + 8 bytes), runs one or two
// compressions, then presents the eight digest words, one per transaction.
// req.ready is low from a finish until the last digest word is taken; rsp stalls
// simply hold the current word. Synchronous reset restores the initial hash.
module sha256_stream_hasher_core
   import shs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   shs_req_if.sink   req,
   shs_rsp_if.source rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WAIT = 3'd1;
   localparam logic [2:0] S_ZERO = 3'd2;
   localparam logic [2:0] S_LEN  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [2:0]  len_cnt_ff, len_cnt_in;
   logic [2:0]  idx_ff, idx_in;

   shs_ctl_type ctl;
   shs_sts_type sts;
   logic        req_fire, rsp_fire;

   shs_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;

   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.digest_word = sts.hash[idx_ff];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'd7);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      len_cnt_in = len_cnt_ff;
      idx_in     = idx_ff;
      ctl        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ctl.push = 1'b1;
               fill_in  = fill_ff + 6'd1;
               if (req.mode == MODE_DATA) begin
                  ctl.push_byte = req.data_byte;
                  bits_in       = bits_ff + 64'd8;
                  ret_in        = S_IDLE;
               end else begin
                  ctl.push_byte = PAD_MARK;
                  ret_in        = S_ZERO;
                  state_in      = S_ZERO;
               end
               if (fill_ff == 6'd63) begin
                  ctl.start = 1'b1;
                  state_in  = S_WAIT;
               end
            end
         end
         S_ZERO: begin
            if (fill_ff == LEN_START) begin
               len_cnt_in = '0;
               state_in   = S_LEN;
            end else begin
               ctl.push = 1'b1;
               fill_in  = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  ctl.start = 1'b1;
                  ret_in    = S_ZERO;
                  state_in  = S_WAIT;
               end
            end
         end
         S_LEN: begin
            // length goes out big-endian; eight shifts also leave the count at zero
            ctl.push      = 1'b1;
            ctl.push_byte = bits_ff[63:56];
            bits_in       = {bits_ff[55:0], 8'h00};
            fill_in       = fill_ff + 6'd1;
            len_cnt_in    = len_cnt_ff + 3'd1;
            if (len_cnt_ff == 3'd7) begin
               ctl.start = 1'b1;
               ret_in    = S_OUT;
               idx_in    = '0;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!sts.busy) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  ctl.init = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_IDLE;
         fill_ff    <= '0;
         bits_ff    <= '0;
         len_cnt_ff <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         len_cnt_ff <= len_cnt_in;
         idx_ff     <= idx_in;
      end
   end

endmodule

[tb/sv/tb_sha256_stream_hasher_core.sv]
// Self-checking testbench for the SHA-256 stream hasher core.
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_core;
   import shs_pkg::*;

   localparam int   ITEM_COUNT  = 300;
   localparam int   STALL_LIMIT = 5000;
   localparam int   HOLD_OFF    = 400;
   localparam int   DRAIN_WAIT  = 200;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        is_last;
   } digest_beat_type;

   // Tracks the running hash and holds the digest words still owed by the core
   class digest_scoreboard_type;
      logic [31:0]     chain [8];
      logic [7:0]      block_bytes [64];
      int unsigned     fill;
      logic [63:0]     msg_bits;
      digest_beat_type pending_words [$];
      int              errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int k = 0; k < 8; k++) chain[k] = HASH_IV[k];
         fill     = 0;
         msg_bits = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void absorb_block();
         logic [31:0] sched [16];
         logic [31:0] v [8];
         logic [31:0] s0, s1, t1, t2, ch, maj, w15, w2, w7;
         int          slot;
         for (int k = 0; k < 16; k++)
            sched[k] = {block_bytes[4*k], block_bytes[4*k+1],
                        block_bytes[4*k+2], block_bytes[4*k+3]};
         for (int k = 0; k < 8; k++) v[k] = chain[k];
         for (int r = 0; r < 64; r++) begin
            slot = r % 16;
            if (r >= 16) begin
               w15 = sched[(r + 1) % 16];
               w2  = sched[(r + 14) % 16];
               w7  = sched[(r + 9) % 16];
               s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
               s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
               sched[slot] = sched[slot] + s0 + w7 + s1;
            end
            s1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + ROUND_K[r] + sched[slot];
            s0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int k = 0; k < 8; k++) chain[k] = chain[k] + v[k];
      endfunction

      function void note_request(logic mode, logic [7:0] data_byte);
         int unsigned     pos;
         logic [63:0]     total;
         digest_beat_type beat;
         if (mode == MODE_DATA) begin
            block_bytes[fill] = data_byte;
            msg_bits = msg_bits + 64'd8;
            fill = (fill + 1) % 64;
            if (fill == 0) absorb_block();
         end else begin
            total = msg_bits;
            pos = fill;
            block_bytes[pos] = PAD_MARK;
            pos = pos + 1;
            // no room left for the length: spill into a second block
            if (pos > LEN_START) begin
               while (pos < 64) begin
                  block_bytes[pos] = 8'h00;
                  pos = pos + 1;
               end
               absorb_block();
               pos = 0;
            end
            while (pos < LEN_START) begin
               block_bytes[pos] = 8'h00;
               pos = pos + 1;
            end
            for (int k = 0; k < 8; k++) block_bytes[63 - k] = total[8*k +: 8];
            absorb_block();
            for (int k = 0; k < 8; k++) begin
               beat.word    = chain[k];
               beat.index   = k[2:0];
               beat.is_last = (k == 7);
               pending_words.push_back(beat);
            end
            restart();
         end
      endfunction

      function void check_word(logic [31:0] word, logic [2:0] index, logic is_last);
         digest_beat_type exp_beat;
         if (pending_words.size() == 0) begin
            $error("digest word %h with no transaction outstanding", word);
            errors++;
            return;
         end
         exp_beat = pending_words.pop_front();
         if (word !== exp_beat.word) begin
            $error("digest_word: expected %h, got %h", exp_beat.word, word);
            errors++;
         end
         if (index !== exp_beat.index) begin
            $error("word_index: expected %0d, got %0d", exp_beat.index, index);
            errors++;
         end
         if (is_last !== exp_beat.is_last) begin
            $error("last_word: expected %0b, got %0b", exp_beat.is_last, is_last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   idle_cycles = 0;

   shs_req_if req_ch ();
   shs_rsp_if rsp_ch ();

   digest_scoreboard_type sb = new();

   sha256_stream_hasher_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #4 clock = ~clock;

   task automatic send_item(input logic mode, input logic [7:0] data_byte);
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.data_byte <= data_byte;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(mode, data_byte);
   endtask

   // mostly back to back, sometimes a short gap, now and then a long one
   task automatic sender_pause();
      int gap;
      case ($urandom_range(0, 19))
         12, 13, 14, 15, 16, 17: gap = $urandom_range(1, 3);
         18:                     gap = $urandom_range(4, 12);
         19:                     gap = $urandom_range(20, 60);
         default:                gap = 0;
      endcase
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_word(rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side back-pressure
   initial begin
      int phase;
      int span;
      rsp_ch.ready <= 1'b0;
      phase = 0;
      wait (reset === 1'b0);
      forever begin
         phase++;
         if (phase == 6) begin
            // long hold-off so the core backs up onto the request side
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  rsp_ch.ready <= 1'b1;
                  span = $urandom_range(1, 40);
               end
               4, 5, 6, 7: begin
                  rsp_ch.ready <= 1'b0;
                  span = $urandom_range(1, 3);
               end
               8: begin
                  rsp_ch.ready <= 1'b0;
                  span = $urandom_range(20, 80);
               end
               default: begin
                  rsp_ch.ready <= 1'b1;
                  span = 200;
               end
            endcase
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      int          items_sent;
      int          msg_len;
      logic [7:0]  pattern [8];
      int          edge_lens [10];
      items_sent = 0;
      pattern    = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h80, 8'h7f, 8'h01, 8'hfe};
      edge_lens  = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 128};
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= MODE_DATA;
      req_ch.data_byte <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty message, then "abc", then a message of bit-pattern bytes
      send_item(MODE_FINISH, 8'hff);
      send_item(MODE_DATA, 8'h61);
      send_item(MODE_DATA, 8'h62);
      send_item(MODE_DATA, 8'h63);
      send_item(MODE_FINISH, 8'h00);
      for (int k = 0; k < 8; k++) begin
         send_item(MODE_DATA, pattern[k]);
         sender_pause();
      end
      send_item(MODE_FINISH, 8'h5a);
      sender_pause();

      // whole messages with random content; lengths lean on the padding boundaries
      while (items_sent < ITEM_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: msg_len = $urandom_range(0, 20);
            5, 6, 7:       msg_len = edge_lens[$urandom_range(0, 9)];
            default:       msg_len = $urandom_range(0, 140);
         endcase
         // last message is cut short so the total stays near the target
         if (msg_len > ITEM_COUNT - items_sent - 1)
            msg_len = ITEM_COUNT - items_sent - 1;
         repeat (msg_len) begin
            send_item(MODE_DATA, 8'($urandom_range(0, 255)));
            items_sent++;
            sender_pause();
         end
         send_item(MODE_FINISH, 8'($urandom_range(0, 255)));
         items_sent++;
         sender_pause();
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
